/* sv/dso_pkg.sv */
// Shared types, constants and helpers for the DDS surface offset block.
package dso_pkg;

  localparam int unsigned FaceW      = 3;
  localparam int unsigned MipW       = 4;
  localparam int unsigned DimW       = 16;
  localparam int unsigned WordW      = 32;
  localparam int unsigned OpBW       = 16;
  localparam int unsigned LvlCntW    = 5;
  localparam int unsigned BppW       = 8;
  localparam int unsigned BlkW       = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned MaxLevelsDef = 16;
  localparam int unsigned MipMax     = (1 << MipW) - 1;

  localparam logic [WordW-1:0] FlagHeight  = 32'h0000_0002;
  localparam logic [WordW-1:0] FlagWidth   = 32'h0000_0004;
  localparam logic [WordW-1:0] FlagLevels  = 32'h0002_0000;
  localparam logic [WordW-1:0] FlagDepth   = 32'h0080_0000;
  localparam logic [WordW-1:0] FlagsReset  = 32'h0000_1001;
  localparam logic [WordW-1:0] HeaderBytes = 32'd128;

  // fourcc codes
  localparam logic [WordW-1:0] FccDxt1 = 32'h3154_5844;
  localparam logic [WordW-1:0] FccAti1 = 32'h3149_5441;
  localparam logic [WordW-1:0] FccDxt2 = 32'h3254_5844;
  localparam logic [WordW-1:0] FccDxt3 = 32'h3354_5844;
  localparam logic [WordW-1:0] FccDxt4 = 32'h3454_5844;
  localparam logic [WordW-1:0] FccDxt5 = 32'h3554_5844;
  localparam logic [WordW-1:0] FccRxgb = 32'h4247_5852;
  localparam logic [WordW-1:0] FccAti2 = 32'h3249_5441;
  localparam logic [WordW-1:0] FccBc3n = 32'h4E33_4342;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFlags     = 3'd0,
    CfgWidth     = 3'd1,
    CfgHeight    = 3'd2,
    CfgDepth     = 3'd3,
    CfgLevels    = 3'd4,
    CfgBlockMode = 3'd5,
    CfgFormat    = 3'd6,
    CfgBpp       = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqMul0,
    SeqMul1,
    SeqMul2,
    SeqAcc,
    SeqFace,
    SeqFin
  } seq_state_e;

  typedef struct packed {
    logic [WordW-1:0]   flags;
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
    logic [DimW-1:0]    depth;
    logic [LvlCntW-1:0] level_count;
    logic               block_mode;
    logic [WordW-1:0]   format_code;
    logic [BppW-1:0]    bits_per_pixel;
  } cfg_t;

  // operand pair for the shared multiplier
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [OpBW-1:0]  b;
  } mul_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] offset;
  } res_t;

  function automatic logic [BlkW-1:0] block_bytes(input logic [WordW-1:0] fcc);
    logic [BlkW-1:0] r;
    case (fcc)
      FccDxt1, FccAti1: r = 5'd8;
      FccDxt2, FccDxt3, FccDxt4, FccDxt5,
      FccRxgb, FccAti2, FccBc3n: r = 5'd16;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DimW-1:0] halve(input logic [DimW-1:0] v);
    logic [DimW-1:0] h;
    h = v >> 1;
    return (h == '0) ? DimW'(1) : h;
  endfunction

endpackage

/* sv/dso_mul.sv */
// Shared 32x16 multiplier, low 32 product bits registered.
module dso_mul (
  input  logic                         clk_i,
  input  dso_pkg::mul_req_t            req_i,
  output logic [dso_pkg::WordW-1:0]    prod_o
);

  localparam int unsigned FullW = dso_pkg::WordW + dso_pkg::OpBW;

  logic [FullW-1:0]          full;
  logic [dso_pkg::WordW-1:0] prod_d, prod_q;

  assign full   = FullW'(req_i.a) * FullW'(req_i.b);
  assign prod_d = full[dso_pkg::WordW-1:0];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

/* sv/dso_seq.sv */
// Level-by-level sequencer: dimension halving, level sizes and running sums.
module dso_seq #(
  parameter int unsigned MAX_LEVELS = dso_pkg::MaxLevelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dso_pkg::cfg_t                 cfg_i,
  input  logic                          start_i,
  input  logic [dso_pkg::FaceW-1:0]     face_i,
  input  logic [dso_pkg::MipW-1:0]      mip_level_i,
  output logic                          busy_o,
  output dso_pkg::mul_req_t             mul_req_o,
  input  logic [dso_pkg::WordW-1:0]     prod_i,
  output dso_pkg::res_t                 res_o,
  input  logic                          res_ready_i
);

  localparam int unsigned LoopMax = (MAX_LEVELS > dso_pkg::MipMax) ? MAX_LEVELS
                                                                   : dso_pkg::MipMax;
  localparam int unsigned CntW = $clog2(LoopMax + 1);

  dso_pkg::seq_state_e state_q, state_d;

  logic [dso_pkg::FaceW-1:0] face_q;
  logic [CntW-1:0]           level_q, last_q, n_q, cnt_q;
  logic [dso_pkg::DimW-1:0]  w_q, h_q, d_q;
  logic [dso_pkg::WordW-1:0] face_sum_q, pre_sum_q;

  logic [CntW-1:0]           n_d, level_d, last_d, cnt_inc;
  logic [dso_pkg::DimW:0]    w_rnd, h_rnd;
  logic [8:0]                bpp_rnd;
  logic [dso_pkg::WordW-1:0] pitch_rnd;

  // level count seen by the face size
  always_comb begin
    if ((cfg_i.flags & dso_pkg::FlagLevels) == '0) begin
      n_d = '0;
    end else if (32'(cfg_i.level_count) > MAX_LEVELS) begin
      n_d = CntW'(MAX_LEVELS);
    end else begin
      n_d = CntW'(cfg_i.level_count);
    end
    level_d = CntW'(mip_level_i);
    last_d  = (n_d > level_d) ? n_d : level_d;
  end

  assign cnt_inc   = cnt_q + CntW'(1);
  assign w_rnd     = {1'b0, w_q} + 17'd3;
  assign h_rnd     = {1'b0, h_q} + 17'd3;
  assign bpp_rnd   = {1'b0, cfg_i.bits_per_pixel} + 9'd7;
  assign pitch_rnd = prod_i + 32'd3;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dso_pkg::SeqIdle: begin
        if (start_i) begin
          state_d = (last_d == '0) ? dso_pkg::SeqFace : dso_pkg::SeqMul0;
        end
      end
      dso_pkg::SeqMul0: state_d = dso_pkg::SeqMul1;
      dso_pkg::SeqMul1: state_d = cfg_i.block_mode ? dso_pkg::SeqAcc : dso_pkg::SeqMul2;
      dso_pkg::SeqMul2: state_d = dso_pkg::SeqAcc;
      dso_pkg::SeqAcc:  state_d = (cnt_inc == last_q) ? dso_pkg::SeqFace : dso_pkg::SeqMul0;
      dso_pkg::SeqFace: state_d = dso_pkg::SeqFin;
      dso_pkg::SeqFin:  state_d = res_ready_i ? dso_pkg::SeqIdle : dso_pkg::SeqFin;
      default:          state_d = dso_pkg::SeqIdle;
    endcase
  end

  // outputs
  always_comb begin
    mul_req_o  = '0;
    res_o      = '0;
    busy_o     = (state_q != dso_pkg::SeqIdle);
    case (state_q)
      dso_pkg::SeqMul0: begin
        if (cfg_i.block_mode) begin
          mul_req_o.a = 32'(dso_pkg::block_bytes(cfg_i.format_code));
          mul_req_o.b = {1'b0, w_rnd[dso_pkg::DimW:2]};
        end else begin
          mul_req_o.a = 32'(w_q);
          mul_req_o.b = 16'(bpp_rnd[8:3]);
        end
      end
      dso_pkg::SeqMul1: begin
        if (cfg_i.block_mode) begin
          mul_req_o.a = prod_i;
          mul_req_o.b = {1'b0, h_rnd[dso_pkg::DimW:2]};
        end else begin
          mul_req_o.a = {pitch_rnd[dso_pkg::WordW-1:2], 2'b00};
          mul_req_o.b = h_q;
        end
      end
      dso_pkg::SeqMul2: begin
        mul_req_o.a = prod_i;
        mul_req_o.b = d_q;
      end
      dso_pkg::SeqFace: begin
        mul_req_o.a = face_sum_q;
        mul_req_o.b = 16'(face_q);
      end
      dso_pkg::SeqFin: begin
        // keep the face product on the multiplier output while the word waits
        mul_req_o.a  = face_sum_q;
        mul_req_o.b  = 16'(face_q);
        res_o.valid  = 1'b1;
        res_o.offset = dso_pkg::HeaderBytes + prod_i + pre_sum_q;
      end
      default: begin
        mul_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dso_pkg::SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == dso_pkg::SeqIdle && start_i) begin
      face_q     <= face_i;
      level_q    <= level_d;
      n_q        <= n_d;
      last_q     <= last_d;
      cnt_q      <= '0;
      face_sum_q <= '0;
      pre_sum_q  <= '0;
      w_q <= ((cfg_i.flags & dso_pkg::FlagWidth)  != '0) ? cfg_i.width  : 16'd1;
      h_q <= ((cfg_i.flags & dso_pkg::FlagHeight) != '0) ? cfg_i.height : 16'd1;
      d_q <= ((cfg_i.flags & dso_pkg::FlagDepth)  != '0) ? cfg_i.depth  : 16'd1;
    end else if (state_q == dso_pkg::SeqAcc) begin
      if (cnt_q < n_q)     face_sum_q <= face_sum_q + prod_i;
      if (cnt_q < level_q) pre_sum_q  <= pre_sum_q + prod_i;
      cnt_q <= cnt_inc;
      w_q   <= dso_pkg::halve(w_q);
      h_q   <= dso_pkg::halve(h_q);
      d_q   <= dso_pkg::halve(d_q);
    end
  end

endmodule

/* sv/dds_surface_offset.sv */
// Top level of the DDS surface offset block: config registers, sequencer, output register.
//
// Returns the file offset of one surface: 128 header bytes, plus face times the
// size of a whole face, plus the sizes of the mip levels ahead of mip_level_i.
// Config words must be written through cfg_we_i/cfg_idx_i/cfg_data_i only while
// the block is idle; the block itself does not enforce this. One query walks mip
// levels 0 .. L-1, L = max(level count, mip level), with the level count taken
// as 0 when its flag is clear and capped at MAX_LEVELS. Each level runs through
// a single shared 32x16 multiplier, with two products and an accumulate for
// block-compressed formats, three products and an accumulate for RGB. A query
// holds in_stall_o high from acceptance through the level steps, the face
// product state SeqFace and SeqFin, where the finished word waits for room in
// the output register; then the result word drops into the output register and
// a new query is taken even while that word still waits behind out_stall_i.
module dds_surface_offset #(
  parameter int unsigned MAX_LEVELS = dso_pkg::MaxLevelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // query channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dso_pkg::FaceW-1:0]     face_i,
  input  logic [dso_pkg::MipW-1:0]      mip_level_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dso_pkg::WordW-1:0]     byte_offset_o,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [dso_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dso_pkg::WordW-1:0]     cfg_data_i
);

  dso_pkg::cfg_t             cfg_q;
  dso_pkg::mul_req_t         mul_req;
  dso_pkg::res_t             res;
  logic [dso_pkg::WordW-1:0] prod;
  logic                      busy;
  logic                      start;
  logic                      res_ready;
  logic                      out_valid_q;
  logic [dso_pkg::WordW-1:0] offset_q;

  // config registers, all reset to zero except the flag word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flags          <= dso_pkg::FlagsReset;
      cfg_q.width          <= '0;
      cfg_q.height         <= '0;
      cfg_q.depth          <= '0;
      cfg_q.level_count    <= '0;
      cfg_q.block_mode     <= 1'b0;
      cfg_q.format_code    <= '0;
      cfg_q.bits_per_pixel <= '0;
    end else if (cfg_we_i) begin
      case (dso_pkg::cfg_idx_e'(cfg_idx_i))
        dso_pkg::CfgFlags:     cfg_q.flags          <= cfg_data_i;
        dso_pkg::CfgWidth:     cfg_q.width          <= cfg_data_i[dso_pkg::DimW-1:0];
        dso_pkg::CfgHeight:    cfg_q.height         <= cfg_data_i[dso_pkg::DimW-1:0];
        dso_pkg::CfgDepth:     cfg_q.depth          <= cfg_data_i[dso_pkg::DimW-1:0];
        dso_pkg::CfgLevels:    cfg_q.level_count    <= cfg_data_i[dso_pkg::LvlCntW-1:0];
        dso_pkg::CfgBlockMode: cfg_q.block_mode     <= cfg_data_i[0];
        dso_pkg::CfgFormat:    cfg_q.format_code    <= cfg_data_i;
        dso_pkg::CfgBpp:       cfg_q.bits_per_pixel <= cfg_data_i[dso_pkg::BppW-1:0];
        default:               cfg_q                <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  // output register frees up when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  dso_seq #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (start),
    .face_i      (face_i),
    .mip_level_i (mip_level_i),
    .busy_o      (busy),
    .mul_req_o   (mul_req),
    .prod_i      (prod),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  dso_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      offset_q <= res.offset;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_offset_o = offset_q;

endmodule

/* sv/dso_chk.sv */
// Port-level assertions for the DDS surface offset block, bound to the top level.
module dso_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [dso_pkg::WordW-1:0]     byte_offset_o
);

  // stalled word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // stalled word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(byte_offset_o))
    else $error("result word changed while stalled");

  // a query keeps the block busy for at least the face product and final add
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("query channel reopened too early");

  // no new result word right behind an accepted query
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result word appeared too early");

endmodule

bind dds_surface_offset dso_chk u_dso_chk (.*);
